FILE: sv/sacs_pkg.sv
package sacs_pkg;
   localparam int TargetBitsDef = 12;
   localparam int TableDepthDef = 8192;
   localparam int StackDepthDef = 64;
   localparam int MaxStepsDef   = 64;
   localparam int ValBits       = 13;

   localparam logic [1:0] KindIdent = 2'd0;
   localparam logic [1:0] KindShift = 2'd1;
   localparam logic [1:0] KindAdd   = 2'd2;
   localparam logic [1:0] KindSub   = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CLEAR, ST_SEED, ST_OUTER_RD, ST_OUTER_WT, ST_INNER_RD, ST_INNER_WT,
      ST_TRY, ST_MK_CHK, ST_MK_WT, ST_MK_WR, ST_DBL, ST_DONE_CHK, ST_DONE_WT, ST_DECIDE,
      ST_WK_TOP, ST_WK_RD1, ST_WK_RD1W, ST_WK_RD2, ST_WK_RD2W, ST_WK_ACT, ST_WK_MK,
      ST_WK_MKW, ST_OUT, ST_FLUSH
   } state_type;
endpackage

FILE: sv/sacs_tables.sv
// value-indexed and entry-indexed stores, one access per cycle each
module sacs_tables #(
   parameter int TABLE_DEPTH = sacs_pkg::TableDepthDef
) (
   input  logic clock,
   input  logic [$clog2(TABLE_DEPTH)-1:0] v_addr,
   input  logic v_we,
   input  logic [$clog2(TABLE_DEPTH)-1:0] v_wentry,
   input  logic v_wmark,
   output logic [$clog2(TABLE_DEPTH)-1:0] v_rentry,
   output logic v_rmark,
   input  logic [$clog2(TABLE_DEPTH)-1:0] e_addr,
   input  logic e_we,
   input  logic [$clog2(TABLE_DEPTH):0] e_wval,
   input  logic [$clog2(TABLE_DEPTH):0] e_wsrc,
   output logic [$clog2(TABLE_DEPTH):0] e_rval,
   output logic [$clog2(TABLE_DEPTH):0] e_rsrc
);
   localparam int AW = $clog2(TABLE_DEPTH);
   logic [AW:0] ent_mem [TABLE_DEPTH];
   logic [AW+1+AW:0] val_mem [TABLE_DEPTH];
   always_ff @(posedge clock) begin
      if (v_we) ent_mem[v_addr] <= {v_wmark, v_wentry};
      v_rentry <= ent_mem[v_addr][AW-1:0];
      v_rmark  <= ent_mem[v_addr][AW];
   end
   always_ff @(posedge clock) begin
      if (e_we) val_mem[e_addr] <= {e_wval, e_wsrc};
      {e_rval, e_rsrc} <= val_mem[e_addr];
   end
endmodule

FILE: sv/sacs_stack.sv
module sacs_stack #(
   parameter int STACK_DEPTH = sacs_pkg::StackDepthDef,
   parameter int TABLE_DEPTH = sacs_pkg::TableDepthDef
) (
   input  logic clock,
   input  logic [$clog2(STACK_DEPTH)-1:0] addr,
   input  logic we,
   input  logic [$clog2(TABLE_DEPTH)+1:0] wdata,
   output logic [$clog2(TABLE_DEPTH)+1:0] rdata
);
   logic [$clog2(TABLE_DEPTH)+1:0] mem [STACK_DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

FILE: sv/shift_add_chain_search_unit.sv
// channel | dir | ports
// req     | in  | req_valid, req_ready, req_target
// rsp     | out | rsp_valid, rsp_ready, rsp_step_kind .. rsp_last
// One target takes a clear sweep over all TABLE_DEPTH value entries, then tries
// each pair (the difference, and the sum when in range) plus each doubling; the
// pair search over the single-port entry store dominates (quadratic in entries).
// Results come one per walk step, stalled while rsp_ready is low; the walk
// runs twice, first counting steps, then emitting, so truncated is known early.
// Reset returns to idle; tables are cleared at the start of every target.
module shift_add_chain_search_unit #(
   parameter int TARGET_BITS = sacs_pkg::TargetBitsDef,
   parameter int TABLE_DEPTH = sacs_pkg::TableDepthDef,
   parameter int STACK_DEPTH = sacs_pkg::StackDepthDef,
   parameter int MAX_STEPS   = sacs_pkg::MaxStepsDef
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [TARGET_BITS-1:0] req_target,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [1:0] rsp_step_kind,
   output logic [sacs_pkg::ValBits-1:0] rsp_step_value,
   output logic [sacs_pkg::ValBits-1:0] rsp_larger_source,
   output logic [sacs_pkg::ValBits-1:0] rsp_smaller_source,
   output logic rsp_truncated,
   output logic rsp_last
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int VW = (AW + 2 > TARGET_BITS + 2) ? AW + 2 : TARGET_BITS + 2;
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = 8;
   localparam int VB = sacs_pkg::ValBits;

   sacs_pkg::state_type state_ff, state_in, ret_ff, ret_in;
   logic [TARGET_BITS-1:0] t_ff, t_in;
   logic [AW:0] cnt_ff, cnt_in, op_ff, op_in, ip_ff, ip_in, clr_ff, clr_in;
   logic [VW-1:0] a_ff, a_in, b_ff, b_in, mv_ff, mv_in, ms_ff, ms_in, dv_ff, dv_in;
   logic phd_ff, phd_in;        // 0: sum next, 1: difference next
   logic mkdbl_ff, mkdbl_in;    // current make comes from a doubling
   logic [SW:0] sp_ff, sp_in;
   logic [VW-1:0] wv_ff, wv_in, big_ff, big_in, sml_ff, sml_in, cand_ff, cand_in;
   logic [1:0] ph_ff, ph_in;
   logic pass_ff, pass_in, cut_ff, cut_in;
   logic [CW-1:0] tot_ff, tot_in, emit_ff, emit_in;
   logic [1:0] okind_ff, okind_in;
   logic [VB-1:0] oval_ff, oval_in, obig_ff, obig_in, osml_ff, osml_in;
   logic olast_ff, olast_in;

   logic [AW-1:0] v_addr, v_wentry, v_rentry, e_addr;
   logic v_we, v_wmark, v_rmark, e_we;
   logic [AW:0] e_wval, e_wsrc, e_rval, e_rsrc;
   logic [SW-1:0] s_addr;
   logic s_we;
   logic [AW+1:0] s_wdata, s_rdata;

   sacs_tables #(.TABLE_DEPTH(TABLE_DEPTH)) u_tab (
      .clock, .v_addr, .v_we, .v_wentry, .v_wmark, .v_rentry, .v_rmark,
      .e_addr, .e_we, .e_wval, .e_wsrc, .e_rval, .e_rsrc);
   sacs_stack #(.STACK_DEPTH(STACK_DEPTH), .TABLE_DEPTH(TABLE_DEPTH)) u_stk (
      .clock, .addr(s_addr), .we(s_we), .wdata(s_wdata), .rdata(s_rdata));

   localparam logic [VW-1:0] DEPTH_V = VW'(TABLE_DEPTH);
   logic [VW-1:0] t_v;
   assign t_v = VW'(t_ff);
   logic mk_ok;
   assign mk_ok = (mv_ff != '0) && (mv_ff < DEPTH_V) && (cnt_ff < (AW+1)'(TABLE_DEPTH));

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; t_in = t_ff; cnt_in = cnt_ff;
      op_in = op_ff; ip_in = ip_ff; clr_in = clr_ff; a_in = a_ff; b_in = b_ff;
      mv_in = mv_ff; ms_in = ms_ff; dv_in = dv_ff; phd_in = phd_ff; mkdbl_in = mkdbl_ff;
      sp_in = sp_ff; wv_in = wv_ff; big_in = big_ff; sml_in = sml_ff; cand_in = cand_ff;
      ph_in = ph_ff; pass_in = pass_ff; cut_in = cut_ff; tot_in = tot_ff; emit_in = emit_ff;
      okind_in = okind_ff; oval_in = oval_ff; obig_in = obig_ff; osml_in = osml_ff;
      olast_in = olast_ff;
      v_addr = mv_ff[AW-1:0]; v_we = 1'b0; v_wentry = '0; v_wmark = 1'b0;
      e_addr = op_ff[AW-1:0]; e_we = 1'b0; e_wval = '0; e_wsrc = '0;
      s_addr = '0; s_we = 1'b0; s_wdata = '0;
      case (state_ff)
         sacs_pkg::ST_IDLE: begin
            if (req_valid) begin
               t_in = req_target; clr_in = '0; state_in = sacs_pkg::ST_CLEAR;
            end
         end
         sacs_pkg::ST_CLEAR: begin
            v_addr = clr_ff[AW-1:0]; v_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(TABLE_DEPTH-1)) begin
               cnt_in = (AW+1)'(1); state_in = sacs_pkg::ST_SEED;
            end
         end
         sacs_pkg::ST_SEED: begin
            mv_in = VW'(1); ms_in = '0; mkdbl_in = 1'b0;
            ret_in = sacs_pkg::ST_DONE_CHK; op_in = '0;
            state_in = sacs_pkg::ST_MK_CHK;
         end
         sacs_pkg::ST_MK_CHK: begin
            if (mk_ok) state_in = sacs_pkg::ST_MK_WT;
            else state_in = mkdbl_ff ? sacs_pkg::ST_DBL : ret_ff;
         end
         sacs_pkg::ST_MK_WT: state_in = sacs_pkg::ST_MK_WR;
         sacs_pkg::ST_MK_WR: begin
            if (v_rentry == '0) begin
               v_we = 1'b1; v_wentry = cnt_ff[AW-1:0];
               e_addr = cnt_ff[AW-1:0]; e_we = 1'b1;
               e_wval = mv_ff[AW:0]; e_wsrc = ms_ff[AW:0];
               cnt_in = cnt_ff + 1'b1;
               dv_in = mv_ff; state_in = sacs_pkg::ST_DBL;
            end else begin
               state_in = mkdbl_ff ? sacs_pkg::ST_DBL : ret_ff;
            end
         end
         sacs_pkg::ST_DBL: begin
            if (dv_ff <= t_v && (dv_ff << 1) < DEPTH_V) begin
               mv_in = dv_ff << 1; ms_in = dv_ff; dv_in = dv_ff << 1;
               mkdbl_in = 1'b1; state_in = sacs_pkg::ST_MK_CHK;
            end else begin
               mkdbl_in = 1'b0; state_in = ret_ff;
            end
         end
         sacs_pkg::ST_DONE_CHK: begin
            v_addr = t_v[AW-1:0];
            if (t_v >= DEPTH_V) state_in = sacs_pkg::ST_IDLE;
            else state_in = sacs_pkg::ST_DONE_WT;
         end
         sacs_pkg::ST_DONE_WT: begin
            v_addr = t_v[AW-1:0];
            state_in = sacs_pkg::ST_DECIDE;
         end
         sacs_pkg::ST_DECIDE: begin
            if (v_rentry != '0) begin
               if (t_v == VW'(1)) begin
                  okind_in = sacs_pkg::KindIdent; oval_in = VB'(1); obig_in = '0;
                  osml_in = '0; olast_in = 1'b1; cut_in = 1'b0;
                  pass_in = 1'b1; emit_in = '0; tot_in = CW'(1);
                  state_in = sacs_pkg::ST_OUT;
               end else begin
                  pass_in = 1'b0; tot_in = '0; emit_in = '0; cut_in = 1'b0;
                  cand_in = t_v; sp_in = '0; state_in = sacs_pkg::ST_WK_MK;
               end
            end else if (op_ff + 1'b1 >= cnt_ff) begin
               state_in = sacs_pkg::ST_IDLE;
            end else begin
               op_in = op_ff + 1'b1; state_in = sacs_pkg::ST_OUTER_RD;
            end
         end
         sacs_pkg::ST_OUTER_RD: begin
            e_addr = op_ff[AW-1:0]; state_in = sacs_pkg::ST_OUTER_WT;
         end
         sacs_pkg::ST_OUTER_WT: begin
            a_in = VW'(e_rval); ip_in = (AW+1)'(1); state_in = sacs_pkg::ST_INNER_RD;
         end
         sacs_pkg::ST_INNER_RD: begin
            if (ip_ff >= op_ff) state_in = sacs_pkg::ST_DONE_CHK;
            else begin
               e_addr = ip_ff[AW-1:0]; state_in = sacs_pkg::ST_INNER_WT;
            end
         end
         sacs_pkg::ST_INNER_WT: begin
            b_in = VW'(e_rval); phd_in = 1'b0; state_in = sacs_pkg::ST_TRY;
         end
         sacs_pkg::ST_TRY: begin
            ms_in = (a_ff >= b_ff) ? a_ff : b_ff; mkdbl_in = 1'b0;
            ret_in = sacs_pkg::ST_TRY;
            if (!phd_ff) begin
               phd_in = 1'b1;
               if (a_ff + b_ff < (t_v << 1)) begin
                  mv_in = a_ff + b_ff; state_in = sacs_pkg::ST_MK_CHK;
               end
            end else begin
               mv_in = (a_ff >= b_ff) ? a_ff - b_ff : b_ff - a_ff;
               ret_in = sacs_pkg::ST_INNER_RD; ip_in = ip_ff + 1'b1;
               state_in = sacs_pkg::ST_MK_CHK;
            end
         end
         // walk: push cand (mark, write stack)
         sacs_pkg::ST_WK_MK: begin
            v_addr = cand_ff[AW-1:0]; state_in = sacs_pkg::ST_WK_MKW;
         end
         sacs_pkg::ST_WK_MKW: begin
            if (sp_ff >= (SW+1)'(STACK_DEPTH)) begin
               cut_in = 1'b1; state_in = sacs_pkg::ST_WK_TOP;
            end else begin
               v_addr = cand_ff[AW-1:0]; v_we = 1'b1;
               v_wentry = v_rentry; v_wmark = ~pass_ff;
               s_addr = sp_ff[SW-1:0]; s_we = 1'b1; s_wdata = {cand_ff[AW-1:0], 2'b00};
               sp_in = sp_ff + 1'b1; state_in = sacs_pkg::ST_WK_TOP;
            end
         end
         sacs_pkg::ST_WK_TOP: begin
            if (sp_ff == '0) begin
               if (!pass_ff && tot_ff != '0) begin
                  pass_in = 1'b1;
                  if (tot_ff > CW'(MAX_STEPS)) begin
                     cut_in = 1'b1; tot_in = CW'(MAX_STEPS);
                  end
                  cand_in = t_v; emit_in = '0; state_in = sacs_pkg::ST_WK_MK;
               end else begin
                  state_in = sacs_pkg::ST_IDLE;
               end
            end else begin
               s_addr = sp_in[SW-1:0] - 1'b1; state_in = sacs_pkg::ST_WK_RD1;
            end
         end
         sacs_pkg::ST_WK_RD1: begin
            s_addr = sp_ff[SW-1:0] - 1'b1; state_in = sacs_pkg::ST_WK_RD1W;
         end
         sacs_pkg::ST_WK_RD1W: begin
            wv_in = VW'(s_rdata[AW+1:2]); ph_in = s_rdata[1:0];
            v_addr = s_rdata[AW+1:2]; state_in = sacs_pkg::ST_WK_RD2;
         end
         sacs_pkg::ST_WK_RD2: begin
            e_addr = v_rentry; state_in = sacs_pkg::ST_WK_RD2W;
         end
         sacs_pkg::ST_WK_RD2W: begin
            big_in = VW'(e_rsrc);
            if (e_rsrc != '0 && (VW'(e_rsrc) << 1) != wv_ff)
               sml_in = (VW'(e_rsrc) < wv_ff) ? wv_ff - VW'(e_rsrc) : VW'(e_rsrc) - wv_ff;
            else sml_in = '0;
            cand_in = (ph_ff == 2'd0) ? VW'(e_rsrc) : sml_in;
            state_in = sacs_pkg::ST_WK_ACT;
         end
         sacs_pkg::ST_WK_ACT: begin
            // read mark of candidate: first cycle issues address
            v_addr = cand_ff[AW-1:0];
            if (ph_ff == 2'd2) begin
               sp_in = sp_ff - 1'b1;
               if ((big_ff << 1) == wv_ff || (big_ff != '0 && sml_ff != '0)) begin
                  okind_in = ((big_ff << 1) == wv_ff) ? sacs_pkg::KindShift :
                             (big_ff > wv_ff) ? sacs_pkg::KindSub : sacs_pkg::KindAdd;
                  oval_in = VB'(wv_ff); obig_in = VB'(big_ff);
                  osml_in = ((big_ff << 1) == wv_ff) ? '0 : VB'(sml_ff);
                  if (!pass_ff) begin
                     if (tot_ff != {CW{1'b1}}) tot_in = tot_ff + 1'b1;
                     state_in = sacs_pkg::ST_WK_TOP;
                  end else if (emit_ff < tot_ff) begin
                     olast_in = (emit_ff + 1'b1 == tot_ff);
                     state_in = sacs_pkg::ST_OUT;
                  end else state_in = sacs_pkg::ST_WK_TOP;
               end else state_in = sacs_pkg::ST_WK_TOP;
            end else begin
               s_addr = sp_ff[SW-1:0] - 1'b1; s_we = 1'b1;
               s_wdata = {wv_ff[AW-1:0], ph_ff + 2'd1};
               state_in = sacs_pkg::ST_FLUSH;
            end
         end
         sacs_pkg::ST_FLUSH: begin
            v_addr = cand_ff[AW-1:0];
            // marks toggle meaning per pass: set = ~pass after a push
            if (cand_ff != '0 && cand_ff < DEPTH_V && (v_rmark == pass_ff))
               state_in = sacs_pkg::ST_WK_MKW;
            else state_in = sacs_pkg::ST_WK_TOP;
         end
         sacs_pkg::ST_OUT: begin
            if (rsp_ready) begin
               emit_in = emit_ff + 1'b1;
               state_in = (t_v == VW'(1)) ? sacs_pkg::ST_IDLE : sacs_pkg::ST_WK_TOP;
            end
         end
         default: state_in = sacs_pkg::ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == sacs_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == sacs_pkg::ST_OUT);
   assign rsp_step_kind = okind_ff;
   assign rsp_step_value = oval_ff;
   assign rsp_larger_source = obig_ff;
   assign rsp_smaller_source = osml_ff;
   assign rsp_truncated = cut_ff;
   assign rsp_last = olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sacs_pkg::ST_IDLE; ret_ff <= sacs_pkg::ST_IDLE;
         sp_ff <= '0; pass_ff <= 1'b0; cut_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; sp_ff <= sp_in;
         pass_ff <= pass_in; cut_ff <= cut_in;
      end
      t_ff <= t_in; cnt_ff <= cnt_in; op_ff <= op_in; ip_ff <= ip_in; clr_ff <= clr_in;
      a_ff <= a_in; b_ff <= b_in; mv_ff <= mv_in; ms_ff <= ms_in; dv_ff <= dv_in;
      phd_ff <= phd_in; mkdbl_ff <= mkdbl_in; wv_ff <= wv_in; big_ff <= big_in;
      sml_ff <= sml_in; cand_ff <= cand_in; ph_ff <= ph_in; tot_ff <= tot_in;
      emit_ff <= emit_in; okind_ff <= okind_in; oval_ff <= oval_in; obig_ff <= obig_in;
      osml_ff <= osml_in; olast_ff <= olast_in;
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_step_value))
      else $error("result word dropped while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= (SW+1)'(STACK_DEPTH)) else $error("walk stack overflow");
endmodule
